[sv/mahh_pkg.sv]
// Package: shared types, defaults and the bitrate tables of the header histogram.
package mahh_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int COUNT_WIDTH_DEF = 16;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TINJ,
    S_TWAIT,
    S_SINJ,
    S_SWAIT,
    S_DIV,
    S_OUT
  } state_e;

  typedef struct packed {
    logic vld;
    logic srch;
    logic hit;
  } tok_ctl_t;

  localparam logic [8:0] RATE_V1 [3][14] = '{
    '{9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd288, 9'd320,
      9'd352, 9'd384, 9'd416, 9'd448},
    '{9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd160, 9'd192,
      9'd224, 9'd256, 9'd320, 9'd384},
    '{9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd160,
      9'd192, 9'd224, 9'd256, 9'd320}
  };

  localparam logic [8:0] RATE_V2 [2][14] = '{
    '{9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160,
      9'd176, 9'd192, 9'd224, 9'd256},
    '{9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
      9'd112, 9'd128, 9'd144, 9'd160}
  };

  function automatic logic [8:0] bitrate_of(logic [23:0] key);
    logic [1:0] ver;
    logic [1:0] lay;
    logic [3:0] idx;
    logic [3:0] pos;
    logic [8:0] r;
    ver = key[12:11];
    lay = key[10:9];
    idx = key[7:4];
    pos = 4'(idx - 4'd1);
    r   = '0;
    if (!(ver == 2'd1 || lay == 2'd0 || idx == 4'd0 || idx == 4'd15)) begin
      if (ver == 2'd3) begin
        r = RATE_V1[2'(2'd3 - lay)][pos];
      end else begin
        r = RATE_V2[(lay == 2'd3) ? 1'b0 : 1'b1][pos];
      end
    end
    return r;
  endfunction

endpackage

[sv/mahh_if.sv]
// Interfaces: the byte input channel and the report output channel.
interface mahh_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        end_of_buffer;
  logic [31:0] file_bytes;
  logic        clear_table;

  modport source (output valid, output data_byte, output end_of_buffer,
                  output file_bytes, output clear_table, input ready);
  modport sink (input valid, input data_byte, input end_of_buffer,
                input file_bytes, input clear_table, output ready);
endinterface

interface mahh_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] best_header;
  logic [15:0] best_count;
  logic [8:0]  bitrate_kbps;
  logic [22:0] duration_seconds;
  logic        table_empty;
  logic        table_overflow;

  modport source (output valid, output best_header, output best_count,
                  output bitrate_kbps, output duration_seconds, output table_empty,
                  output table_overflow, input ready);
  modport sink (input valid, input best_header, input best_count,
                input bitrate_kbps, input duration_seconds, input table_empty,
                input table_overflow, output ready);
endinterface

[sv/mahh_cell.sv]
// Cell: one table entry that updates or bids on a token passing down the chain.
module mahh_cell import mahh_pkg::*; #(
  parameter int IDX         = 0,
  parameter int UW          = 5,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [UW-1:0]          used_i,
  input  logic                   ins_i,
  input  logic [23:0]            ins_key_i,
  input  tok_ctl_t               ctl_i,
  input  logic [23:0]            key_i,
  input  logic [COUNT_WIDTH-1:0] cnt_i,
  output tok_ctl_t               ctl_o,
  output logic [23:0]            key_o,
  output logic [COUNT_WIDTH-1:0] cnt_o
);

  logic [23:0]            key_q;
  logic [COUNT_WIDTH-1:0] cnt_q;
  tok_ctl_t               ctl_q;
  logic [23:0]            tkey_q;
  logic [COUNT_WIDTH-1:0] tcnt_q;
  logic                   used;

  assign used = UW'(IDX) < used_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
      if (ctl_i.vld && used) begin
        if (!ctl_i.srch && !ctl_i.hit && key_q == key_i) begin
          ctl_q.hit <= 1'b1;
        end else if (ctl_i.srch && (!ctl_i.hit || cnt_q > cnt_i)) begin
          ctl_q.hit <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tkey_q <= key_i;
    tcnt_q <= cnt_i;
    if (ctl_i.vld && used) begin
      if (!ctl_i.srch && !ctl_i.hit && key_q == key_i) begin
        if (cnt_q != '1) begin
          cnt_q <= cnt_q + 1'b1;
        end
      end else if (ctl_i.srch && (!ctl_i.hit || cnt_q > cnt_i)) begin
        tkey_q <= key_q;
        tcnt_q <= cnt_q;
      end
    end
    if (ins_i && used_i == UW'(IDX)) begin
      key_q <= ins_key_i;
      cnt_q <= COUNT_WIDTH'(1);
    end
  end

  assign ctl_o = ctl_q;
  assign key_o = tkey_q;
  assign cnt_o = tcnt_q;

endmodule

[sv/mahh_div.sv]
// Divider: restoring division of bit-scaled file size by bitrate, one bit a cycle.
module mahh_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [34:0] dividend_i,
  input  logic [18:0] divisor_i,
  output logic        done_o,
  output logic [22:0] quot_o
);

  logic [34:0] dvd_q;
  logic [18:0] dsr_q;
  logic [19:0] rem_q;
  logic [5:0]  cnt_q;
  logic        busy_q;
  logic        done_q;
  logic [19:0] shifted;
  logic [20:0] diff;

  assign shifted = {rem_q[18:0], dvd_q[34]};
  assign diff    = {1'b0, shifted} - {2'b00, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd35;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      if (!diff[20]) begin
        rem_q <= diff[19:0];
        dvd_q <= {dvd_q[33:0], 1'b1};
      end else begin
        rem_q <= shifted;
        dvd_q <= {dvd_q[33:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q[22:0];

endmodule

[sv/mpeg_audio_header_histogram.sv]
// Top level: MPEG audio frame header finder with a chained header table and report.
// One byte word is taken per cycle while no header tally or report is pending. A byte that
// completes a counted header stalls the input while the tally token runs down the chain
// of table cells; an end-of-buffer word adds the maximum search through the same chain
// and, for a nonzero bitrate, the bit-serial duration divider, and then waits until the
// report word is taken.
module mpeg_audio_header_histogram import mahh_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  mahh_in_if.sink    in_i,
  mahh_out_if.source out_o
);

  localparam int UW = $clog2(TABLE_DEPTH + 1);

  state_e state_q, state_d;

  logic [7:0]  win_q [4];
  logic [2:0]  fill_q;
  logic [2:0]  skip_q;
  logic [23:0] key_q;
  logic        last_q;
  logic [31:0] fb_q;
  logic [UW-1:0] used_q;
  logic        ovf_q;

  logic [23:0] hdr_q;
  logic [15:0] bcnt_q;
  logic [8:0]  rate_q;
  logic [22:0] dur_q;
  logic        empty_q;

  tok_ctl_t               ctl_c [TABLE_DEPTH+1];
  logic [23:0]            key_c [TABLE_DEPTH+1];
  logic [COUNT_WIDTH-1:0] cnt_c [TABLE_DEPTH+1];

  logic        acc;
  logic        is_hdr;
  logic        do_tally;
  logic        inject;
  logic        ins;
  logic        div_start;
  logic        div_done;
  logic [22:0] div_quot;
  logic [8:0]  end_rate;
  logic [31:0] cnt_wide;
  tok_ctl_t    end_ctl;

  assign acc     = in_i.valid && in_i.ready;
  assign end_ctl = ctl_c[TABLE_DEPTH];
  assign end_rate = bitrate_of(key_c[TABLE_DEPTH]);
  assign cnt_wide = 32'(cnt_c[TABLE_DEPTH]);

  always_comb begin
    is_hdr = (win_q[0] == 8'hFF) && (win_q[1] > 8'hE0) &&
             ((win_q[1] & 8'h18) != 8'h08) && ((win_q[1] & 8'h06) != 8'h00) &&
             ((win_q[2] & 8'hF0) != 8'hF0) && ((win_q[2] & 8'hF0) != 8'h00) &&
             ((win_q[2] & 8'h0C) != 8'h0C);
    do_tally = (fill_q >= 3'd4) && (skip_q == 3'd0) && is_hdr;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          if (do_tally) begin
            state_d = S_TINJ;
          end else if (in_i.end_of_buffer) begin
            state_d = S_SINJ;
          end
        end
      end
      S_TINJ: state_d = S_TWAIT;
      S_TWAIT: begin
        if (end_ctl.vld) begin
          state_d = last_q ? S_SINJ : S_IDLE;
        end
      end
      S_SINJ: state_d = S_SWAIT;
      S_SWAIT: begin
        if (end_ctl.vld) begin
          state_d = div_start ? S_DIV : S_OUT;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_o.ready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready  = (state_q == S_IDLE);
    out_o.valid = (state_q == S_OUT);
    inject      = (state_q == S_TINJ) || (state_q == S_SINJ);
    ins         = (state_q == S_TWAIT) && end_ctl.vld && !end_ctl.hit &&
                  (used_q < UW'(TABLE_DEPTH));
    div_start   = (state_q == S_SWAIT) && end_ctl.vld && end_ctl.hit && (end_rate != 9'd0);
  end

  assign ctl_c[0] = '{vld: inject, srch: (state_q == S_SINJ), hit: 1'b0};
  assign key_c[0] = key_q;
  assign cnt_c[0] = '0;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    mahh_cell #(
      .IDX        (g),
      .UW         (UW),
      .COUNT_WIDTH(COUNT_WIDTH)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .used_i   (used_q),
      .ins_i    (ins),
      .ins_key_i(key_q),
      .ctl_i    (ctl_c[g]),
      .key_i    (key_c[g]),
      .cnt_i    (cnt_c[g]),
      .ctl_o    (ctl_c[g+1]),
      .key_o    (key_c[g+1]),
      .cnt_o    (cnt_c[g+1])
    );
  end

  mahh_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i({fb_q, 3'b000}),
    .divisor_i (19'(end_rate) * 19'd1000),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
      skip_q  <= '0;
      used_q  <= '0;
      ovf_q   <= 1'b0;
      last_q  <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (acc) begin
        last_q <= in_i.end_of_buffer;
        if (in_i.clear_table) begin
          used_q <= '0;
          ovf_q  <= 1'b0;
        end
        if (fill_q >= 3'd4) begin
          if (skip_q != 3'd0) begin
            skip_q <= skip_q - 3'd1;
          end else if (is_hdr) begin
            skip_q <= 3'd4;
          end
          win_q[0] <= win_q[1];
          win_q[1] <= win_q[2];
          win_q[2] <= win_q[3];
          win_q[3] <= in_i.data_byte;
        end else begin
          win_q[fill_q[1:0]] <= in_i.data_byte;
          fill_q <= fill_q + 3'd1;
        end
        if (in_i.end_of_buffer) begin
          fill_q <= '0;
          skip_q <= '0;
        end
      end
      if (state_q == S_TWAIT && end_ctl.vld && !end_ctl.hit) begin
        if (used_q < UW'(TABLE_DEPTH)) begin
          used_q <= used_q + 1'b1;
        end else begin
          ovf_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      key_q <= {win_q[0], win_q[1], win_q[2]};
      fb_q  <= in_i.file_bytes;
    end
    if (state_q == S_SWAIT && end_ctl.vld) begin
      dur_q   <= '0;
      empty_q <= !end_ctl.hit;
      if (end_ctl.hit) begin
        hdr_q  <= key_c[TABLE_DEPTH];
        bcnt_q <= (cnt_wide > 32'h0000FFFF) ? 16'hFFFF : cnt_wide[15:0];
        rate_q <= end_rate;
      end else begin
        hdr_q  <= '0;
        bcnt_q <= '0;
        rate_q <= '0;
      end
    end
    if (state_q == S_DIV && div_done) begin
      dur_q <= div_quot;
    end
  end

  assign out_o.best_header      = hdr_q;
  assign out_o.best_count       = bcnt_q;
  assign out_o.bitrate_kbps     = rate_q;
  assign out_o.duration_seconds = dur_q;
  assign out_o.table_empty      = empty_q;
  assign out_o.table_overflow   = ovf_q;

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= UW'(TABLE_DEPTH))
    else $error("Table fill count exceeds the depth.");

  a_no_accept_while_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !in_i.ready)
    else $error("Byte word accepted while a report is pending.");

  a_last_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && in_i.end_of_buffer) |=> !in_i.ready)
    else $error("End of buffer did not start a report.");

  a_token_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_ctl.vld |-> (state_q == S_TWAIT || state_q == S_SWAIT))
    else $error("Chain token emerged outside a wait state.");

endmodule

[sim/tb_mpeg_audio_header_histogram.sv]
// Testbench: byte streams with MPEG audio headers, checked against a local header histogram model.
module tb_mpeg_audio_header_histogram;
  import mahh_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEF;
  localparam int CMAX = (1 << COUNT_WIDTH_DEF) - 1;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [23:0] hdr;
    logic [15:0] cnt;
    logic [8:0]  rate;
    logic [22:0] dur;
    logic        empty;
    logic        ovf;
  } report_t;

  class histogram_board;
    logic [7:0]  win [4];
    int          fill;
    int          skip;
    logic [23:0] keys [DEPTH];
    int          counts [DEPTH];
    int          used;
    bit          ovf;
    report_t     pending [$];
    int          errors;
    int          reports;

    function void clear();
      fill = 0;
      skip = 0;
      used = 0;
      ovf = 0;
      errors = 0;
      reports = 0;
      foreach (win[i]) win[i] = '0;
    endfunction

    function bit valid_header(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2);
      return b0 == 8'hFF && b1 > 8'hE0 && (b1 & 8'h18) != 8'h08 && (b1 & 8'h06) != 0 &&
             (b2 & 8'hF0) != 8'hF0 && (b2 & 8'hF0) != 0 && (b2 & 8'h0C) != 8'h0C;
    endfunction

    function logic [8:0] rate_of(logic [23:0] key);
      logic [1:0] ver;
      logic [1:0] lay;
      int         idx;
      ver = key[12:11];
      lay = key[10:9];
      idx = key[7:4];
      if (ver == 2'd1 || lay == 2'd0 || idx == 0 || idx == 15) return '0;
      if (ver == 2'd3) return RATE_V1[3 - lay][idx - 1];
      return RATE_V2[(lay == 2'd3) ? 0 : 1][idx - 1];
    endfunction

    function void count_header(logic [23:0] key);
      for (int k = 0; k < used; k++) begin
        if (keys[k] == key) begin
          if (counts[k] < CMAX) counts[k]++;
          return;
        end
      end
      if (used < DEPTH) begin
        keys[used] = key;
        counts[used] = 1;
        used++;
      end else begin
        ovf = 1;
      end
    endfunction

    function void note_byte(logic [7:0] b, bit last, logic [31:0] fbytes, bit clr);
      report_t r;
      int      best;
      longint  rate;
      if (clr) begin
        used = 0;
        ovf = 0;
      end
      if (fill >= 4) begin
        if (skip > 0) begin
          skip--;
        end else if (valid_header(win[0], win[1], win[2])) begin
          count_header({win[0], win[1], win[2]});
          skip = 4;
        end
        win[0] = win[1];
        win[1] = win[2];
        win[2] = win[3];
        win[3] = b;
      end else begin
        win[fill] = b;
        fill++;
      end
      if (!last) return;
      fill = 0;
      skip = 0;
      r = '0;
      r.ovf = ovf;
      if (used == 0) begin
        r.empty = 1'b1;
      end else begin
        best = 0;
        for (int k = 1; k < used; k++) if (counts[k] > counts[best]) best = k;
        r.hdr = keys[best];
        r.cnt = counts[best];
        r.rate = rate_of(keys[best]);
        rate = r.rate;
        if (rate != 0) r.dur = 23'((longint'(fbytes) * 8) / (rate * 1000));
      end
      pending.push_back(r);
    endfunction

    function void check_report(report_t got);
      report_t w;
      reports++;
      if (pending.size() == 0) begin
        $error("unexpected report word: %h", got);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (got.hdr !== w.hdr) begin
        $error("best_header: expected %h, got %h", w.hdr, got.hdr);
        errors++;
      end
      if (got.cnt !== w.cnt) begin
        $error("best_count: expected %0d, got %0d", w.cnt, got.cnt);
        errors++;
      end
      if (got.rate !== w.rate) begin
        $error("bitrate_kbps: expected %0d, got %0d", w.rate, got.rate);
        errors++;
      end
      if (got.dur !== w.dur) begin
        $error("duration_seconds: expected %0d, got %0d", w.dur, got.dur);
        errors++;
      end
      if (got.empty !== w.empty) begin
        $error("table_empty: expected %0b, got %0b", w.empty, got.empty);
        errors++;
      end
      if (got.ovf !== w.ovf) begin
        $error("table_overflow: expected %0b, got %0b", w.ovf, got.ovf);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  mahh_in_if  in_ch ();
  mahh_out_if out_ch ();
  histogram_board board;
  int   idle_cycles;
  int   sent;
  bit   timed_out;
  logic [23:0] pool [8];

  mpeg_audio_header_histogram dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (out_ch.valid && out_ch.ready) begin
        board.check_report({out_ch.best_header, out_ch.best_count, out_ch.bitrate_kbps,
                            out_ch.duration_seconds, out_ch.table_empty,
                            out_ch.table_overflow});
      end
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= STALL_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int gap;
    out_ch.ready = 1'b0;
    forever begin
      gap = $urandom_range(0, 11);
      @(negedge clk_i);
      out_ch.ready = 1'b0;
      repeat (gap) @(negedge clk_i);
      out_ch.ready = 1'b1;
      do @(posedge clk_i); while (!(out_ch.valid && out_ch.ready));
    end
  end

  task automatic send_byte(logic [7:0] b, bit last = 0, logic [31:0] fbytes = 0,
                           bit clr = 0, bit burst = 0);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid = 1'b1;
    in_ch.data_byte = b;
    in_ch.end_of_buffer = last;
    in_ch.file_bytes = fbytes;
    in_ch.clear_table = clr;
    do @(posedge clk_i); while (!in_ch.ready);
    board.note_byte(b, last, fbytes, clr);
    sent++;
    @(negedge clk_i);
    in_ch.valid = 1'b0;
  endtask

  task automatic send_header(logic [23:0] h, bit burst);
    send_byte(h[23:16], 0, 0, 0, burst);
    send_byte(h[15:8], 0, 0, 0, burst);
    send_byte(h[7:0], 0, 0, 0, burst);
    send_byte(8'($urandom), 0, 0, 0, burst);
  endtask

  function automatic logic [23:0] random_header();
    logic [7:0] b1;
    logic [7:0] b2;
    do b1 = 8'($urandom_range(8'hE1, 8'hFF)); while ((b1 & 8'h18) == 8'h08 || (b1 & 8'h06) == 0);
    do b2 = 8'($urandom); while ((b2 & 8'hF0) == 8'hF0 || (b2 & 8'hF0) == 0 ||
                                 (b2 & 8'h0C) == 8'h0C);
    return {8'hFF, b1, b2};
  endfunction

  task automatic random_buffer(bit clr, int nhdr, int npool);
    bit burst;
    logic [31:0] fb;
    burst = ($urandom_range(0, 3) == 0);
    send_byte(8'($urandom), 0, 0, clr, burst);
    for (int i = 0; i < nhdr; i++) begin
      case ($urandom_range(0, 5))
        0: send_byte(8'($urandom), 0, 0, 0, burst);
        1: send_header({8'hFF, 8'($urandom), 8'($urandom)}, burst);
        2: send_byte(8'hFF, 0, 0, 0, burst);
        3: send_header(random_header(), burst);
        default: send_header(pool[$urandom_range(0, npool - 1)], burst);
      endcase
    end
    for (int i = $urandom_range(0, 5); i > 0; i--) send_byte(8'($urandom), 0, 0, 0, burst);
    case ($urandom_range(0, 3))
      0: fb = '1;
      1: fb = 32'($urandom_range(0, 1000));
      default: fb = $urandom;
    endcase
    send_byte(8'($urandom), 1, fb, 0, burst);
  endtask

  initial begin
    board = new();
    board.clear();
    idle_cycles = 0;
    sent = 0;
    timed_out = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.end_of_buffer = 1'b0;
    in_ch.file_bytes = '0;
    in_ch.clear_table = 1'b0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty report, short buffer, lag at buffer end, tie, extreme rates.
    send_byte(8'h00, 1, 32'hFFFF_FFFF);
    send_byte(8'hFF);
    send_byte(8'hFB);
    send_byte(8'h90);
    send_byte(8'h00, 1, 32'd100);
    send_header(24'hFF_FB_E0, 1);
    send_header(24'hFF_F3_10, 1);
    send_header(24'hFF_E3_E4, 0);
    send_byte(8'hFF);
    send_byte(8'hFB);
    send_byte(8'h90);
    send_byte(8'h00, 1, 32'hFFFF_FFFF);
    send_header(24'hFF_E1_10, 0);
    send_header(24'hFF_FF_10, 0);
    send_byte(8'h55, 1, 32'd7, 1);

    for (int i = 0; i < 8; i++) pool[i] = random_header();
    while (sent < 1750) begin
      case ($urandom_range(0, 9))
        0: random_buffer($urandom_range(0, 1), $urandom_range(0, 3), 8);
        1: begin
          // Many random headers to fill the table past its depth.
          send_byte(8'h00, 0, 0, 1);
          for (int i = 0; i < DEPTH + 3; i++) send_header(random_header(), 1);
          send_byte(8'h00, 0, 0, 0, 1);
          send_byte(8'h00, 0, 0, 0, 1);
          send_byte(8'h00, 0, 0, 0, 1);
          send_byte(8'h00, 1, $urandom, 0, 1);
        end
        default: random_buffer($urandom_range(0, 7) == 0, $urandom_range(2, 20),
                               $urandom_range(1, 8));
      endcase
      if (sent > 900 && sent < 1000) begin
        while (board.pending.size() != 0) @(negedge clk_i);
        repeat (100) @(negedge clk_i);
      end
    end

    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    $display("Sent %0d bytes, checked %0d buffer reports with random handshake gaps.",
             sent, board.reports);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
